FILE: rtl/hbp_pkg.sv
// Shared constants, types and item structures for the table-driven bit packer.
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

	localparam int MAX_CODE_LEN  = 32;
	localparam int ALPHABET_SIZE = 256;

	localparam int LEN_LIMIT   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int TABLE_DEPTH = (ALPHABET_SIZE < 256) ? ALPHABET_SIZE : 256;
	localparam int TAB_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;

	// Accumulator holds up to seven leftover bits plus one full code.
	localparam int ACC_W = 7 + CODE_W;
	localparam int CNT_W = 6;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int BQDEPTH = 2;
	localparam int BQPTR_W = $clog2(BQDEPTH);
	localparam int BQCNT_W = $clog2(BQDEPTH + 1);

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_RAW    = 2'd2,
		REQ_FLUSH  = 2'd3
	} req_e_t;

	typedef struct packed {
		req_e_t              req_type;
		logic [SYM_W-1:0]    symbol;
		logic [CODE_W-1:0]   code_bits;
		logic [LEN_W-1:0]    code_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// Work passed from the front to the packer: bits are already masked to len.
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} op_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] lim;
		lim = LEN_W'(LEN_LIMIT);
		return (len > lim) ? lim : len;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/hbp_front.sv
// Front end: accepts items, holds the code table and turns items into packer operations.
`timescale 1ns / 1ps
`default_nettype none
module hbp_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire hbp_pkg::in_item_t      item,
	input  wire logic [hbp_pkg::QCNT_W-1:0] op_level,
	output logic                        op_push,
	output hbp_pkg::op_t                op
);
	import hbp_pkg::*;

	logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
	logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic              accept;
	logic              in_range;
	logic [TAB_AW-1:0] idx;
	logic [LEN_W-1:0]  len_in;

	logic              v_s1;
	req_e_t            type_s1;
	logic              hit_s1;
	logic [CODE_W-1:0] raw_bits_s1;
	logic [LEN_W-1:0]  raw_len_s1;
	logic [CODE_W-1:0] rd_code_s1;
	logic [LEN_W-1:0]  rd_len_s1;

	logic [CODE_W-1:0] sel_bits;
	logic [LEN_W-1:0]  sel_len;
	logic [CODE_W-1:0] mask;

	// Room is reserved for the item in flight so stage one never has to stall.
	assign full = ((QCNT_W + 1)'(op_level) + (QCNT_W + 1)'(v_s1)) >= (QCNT_W + 1)'(QDEPTH);
	assign accept   = push && !full;
	assign in_range = {1'b0, item.symbol} < (SYM_W + 1)'(TABLE_DEPTH);
	assign idx      = item.symbol[TAB_AW-1:0];
	assign len_in   = clamp_len(item.code_length);

	always_ff @(posedge clk) begin
		if (accept && item.req_type == REQ_LOAD && in_range) begin
			code_mem[idx] <= item.code_bits;
			len_mem[idx]  <= len_in;
		end
		if (accept) begin
			rd_code_s1  <= code_mem[idx];
			rd_len_s1   <= len_mem[idx];
			type_s1     <= item.req_type;
			raw_bits_s1 <= item.code_bits;
			raw_len_s1  <= len_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			v_s1   <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (accept && item.req_type == REQ_LOAD && in_range) begin
				vld_q[idx] <= 1'b1;
			end
			v_s1 <= accept && item.req_type != REQ_LOAD;
			if (accept) begin
				hit_s1 <= in_range && vld_q[idx];
			end
		end
	end

	always_comb begin
		sel_bits = raw_bits_s1;
		sel_len  = '0;
		unique case (type_s1)
			REQ_ENCODE: begin
				sel_bits = rd_code_s1;
				sel_len  = hit_s1 ? rd_len_s1 : '0;
			end
			REQ_RAW: begin
				sel_bits = raw_bits_s1;
				sel_len  = raw_len_s1;
			end
			REQ_LOAD, REQ_FLUSH: begin
				sel_len = '0;
			end
			default: sel_len = '0;
		endcase
	end

	assign mask     = CODE_W'(((CODE_W + 1)'(1) << sel_len) - (CODE_W + 1)'(1));
	assign op.flush = (type_s1 == REQ_FLUSH);
	assign op.bits  = sel_bits & mask;
	assign op.len   = sel_len;
	assign op_push  = v_s1 && (op.flush || sel_len != '0);

endmodule
`default_nettype wire

FILE: rtl/hbp_op_queue.sv
// Short queue of packer operations between the front end and the packer.
`timescale 1ns / 1ps
`default_nettype none
module hbp_op_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire hbp_pkg::op_t               wr,
	input  wire logic                       pop,
	output hbp_pkg::op_t                    rd,
	output logic                            empty,
	output logic [hbp_pkg::QCNT_W-1:0]      level
);
	import hbp_pkg::*;

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign empty  = (cnt_q == '0);
	assign level  = cnt_q;
	assign rd     = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/hbp_pack.sv
// Packer: gathers operation bits MSB first and cuts them into bytes, one byte per cycle while the byte queue has room.
`timescale 1ns / 1ps
`default_nettype none
module hbp_pack (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hbp_pkg::op_t        op,
	input  wire logic                op_empty,
	output logic                     op_pop,
	input  wire logic                byte_full,
	output logic                     byte_push,
	output hbp_pkg::out_item_t       byte_item
);
	import hbp_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;

	logic             emit;
	logic [CNT_W-1:0] cnt_left;
	logic [CNT_W-1:0] cnt_rem;
	logic             take_app;
	logic             take_fl;
	logic             fl_byte;
	logic [2:0]       pad;

	assign cnt_left = cnt_q - CNT_W'(8);
	assign emit     = (cnt_q >= CNT_W'(8)) && !byte_full;
	assign cnt_rem  = emit ? cnt_left : cnt_q;

	// An append may go in the same cycle as a byte leaves, once fewer than eight bits remain.
	assign take_app = !op_empty && !op.flush && (cnt_rem < CNT_W'(8));
	assign take_fl  = !op_empty && op.flush && (cnt_q < CNT_W'(8)) &&
	                  (cnt_q == '0 || !byte_full);
	assign fl_byte  = take_fl && (cnt_q != '0);
	assign op_pop   = take_app || take_fl;
	assign pad      = 3'(CNT_W'(8) - cnt_q);

	always_comb begin
		byte_push             = 1'b0;
		byte_item.out_byte    = 8'(acc_q >> cnt_left);
		byte_item.last_of_run = (cnt_left < CNT_W'(8));
		if (emit) begin
			byte_push = 1'b1;
		end else if (fl_byte) begin
			byte_push             = 1'b1;
			byte_item.out_byte    = acc_q[7:0] << pad;
			byte_item.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take_app) begin
				acc_q <= (acc_q << op.len) | ACC_W'(op.bits);
				cnt_q <= cnt_rem + CNT_W'(op.len);
			end else if (take_fl) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_rem;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/hbp_byte_queue.sv
// Output queue of packed bytes; decouples the packer from the result consumer.
`timescale 1ns / 1ps
`default_nettype none
module hbp_byte_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire hbp_pkg::out_item_t   wr,
	output logic                      full,
	input  wire logic                 pop,
	output hbp_pkg::out_item_t        rd,
	output logic                      empty
);
	import hbp_pkg::*;

	out_item_t          mem_q [BQDEPTH];
	logic [BQPTR_W-1:0] wr_ptr_q;
	logic [BQPTR_W-1:0] rd_ptr_q;
	logic [BQCNT_W-1:0] cnt_q;
	logic               do_pop;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == BQCNT_W'(BQDEPTH));
	assign rd     = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + BQPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + BQPTR_W'(1);
			end
			cnt_q <= cnt_q + BQCNT_W'(push) - BQCNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/huffman_table_bit_packer.sv
// Top level of the table-driven Huffman bit packer.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one item per cycle while full is low: a load writes a code and its
// length into a 256-entry table, an encode looks a byte up in that table, a raw item
// supplies its bits directly and a flush pads the leftover bits with zeros. Packed bytes
// come out MSB first, at most one per cycle, the last byte caused by an item carrying
// last_of_run. An item passes the front stage (table read), the operation queue and the
// packer's accumulator before its first byte enters the output queue; a flush byte is
// cut straight from the head of the operation queue. The packer adds one item per cycle
// while it emits bytes, so the rate is one item per cycle as long as the stream averages
// at most eight bits per item and the output queue does not fill; longer codes are limited
// by the single-byte output and back up through a four-entry operation queue, after which
// full is raised. A table load takes effect for an encode accepted in the very next cycle.
module huffman_table_bit_packer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire hbp_pkg::in_item_t    item,
	output logic                      empty,
	input  wire logic                 pop,
	output hbp_pkg::out_item_t        result
);
	import hbp_pkg::*;

	logic              op_push;
	op_t               op_wr;
	op_t               op_rd;
	logic              op_empty;
	logic              op_pop;
	logic [QCNT_W-1:0] op_level;
	logic              byte_full;
	logic              byte_push;
	out_item_t         byte_item;

	hbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.op_level (op_level),
		.op_push  (op_push),
		.op       (op_wr)
	);

	hbp_op_queue u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wr     (op_wr),
		.pop    (op_pop),
		.rd     (op_rd),
		.empty  (op_empty),
		.level  (op_level)
	);

	hbp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_rd),
		.op_empty  (op_empty),
		.op_pop    (op_pop),
		.byte_full (byte_full),
		.byte_push (byte_push),
		.byte_item (byte_item)
	);

	hbp_byte_queue u_byte_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (byte_push),
		.wr     (byte_item),
		.full   (byte_full),
		.pop    (pop),
		.rd     (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire
